### hdl/pirc_pkg.sv
// Shared types and constants of the packet insertion rate controller.
package pirc_pkg;

  localparam int unsigned RateWidthDef  = 32;
  localparam int unsigned CountWidthDef = 32;

  localparam int unsigned AccelW  = 8;
  localparam int unsigned SampleW = 32;
  localparam int unsigned DiffW   = 64;
  localparam int unsigned DivW    = 64;
  localparam int unsigned WaitW   = 16;
  localparam int unsigned PctW    = 10;
  localparam int unsigned CountInW = 16;
  localparam int unsigned BitRateW = 32;

  localparam logic [6:0] PERCENT_SCALE = 7'd100;

  localparam logic [WaitW-1:0] WAIT_ALERT_RST = 16'd16;
  localparam logic [PctW-1:0]  RESET_PCT_RST  = 10'd10;

  localparam logic CFG_WAIT_ALERT = 1'b0;
  localparam logic CFG_RESET_PCT  = 1'b1;

  localparam logic [2:0] REQ_MAIN_RATE = 3'd0;
  localparam logic [2:0] REQ_SUB_RATE  = 3'd1;
  localparam logic [2:0] REQ_MAIN_PKTS = 3'd2;
  localparam logic [2:0] REQ_SUB_PKTS  = 3'd3;
  localparam logic [2:0] REQ_QUERY     = 3'd4;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

endpackage

### hdl/pirc_seq_unit.sv
// Shared bit-serial multiply and restoring divide unit.
module pirc_seq_unit import pirc_pkg::*; #(
  parameter int unsigned RATE_WIDTH  = RateWidthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef,
  localparam int unsigned ProdW = COUNT_WIDTH + AccelW + RATE_WIDTH,
  localparam int unsigned ResW  = (ProdW > DivW) ? ProdW : DivW,
  localparam int unsigned BW    = (RATE_WIDTH > SampleW) ? RATE_WIDTH : SampleW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  unit_req_t       req_i,
  input  logic [DivW-1:0] a_i,
  input  logic [BW-1:0]   b_i,
  output logic            done_o,
  output logic [ResW-1:0] res_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic              busy_q;
  logic              done_q;
  unit_op_e          op_q;
  logic [CntW-1:0]   cnt_q;
  logic [ResW-1:0]   acc_q, acc_d;
  logic [DivW-1:0]   a_q;
  logic [BW-1:0]     b_q;
  logic [SampleW-1:0] rem_q, rem_d;
  logic [SampleW:0]  rem_sh;
  logic [SampleW:0]  rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_q, acc_q[DivW-1]};
    ge      = (rem_sh >= {1'b0, b_q[SampleW-1:0]});
    rem_sub = rem_sh - {1'b0, b_q[SampleW-1:0]};
    if (op_q == OP_MUL) begin
      acc_d = (acc_q << 1) + (b_q[RATE_WIDTH-1] ? ResW'(a_q) : '0);
      rem_d = rem_q;
    end else begin
      acc_d = {acc_q[ResW-2:0], ge};
      rem_d = ge ? rem_sub[SampleW-1:0] : rem_sh[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == CntW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == OP_MUL) ? CntW'(RATE_WIDTH) : CntW'(DivW);
        acc_q  <= (req_i.op == OP_DIV) ? ResW'(a_i) : '0;
        a_q    <= a_i;
        b_q    <= b_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        acc_q <= acc_d;
        rem_q <= rem_d;
        // The multiplier bits are scanned from the top; the divisor stays put.
        if (op_q == OP_MUL) begin
          b_q <= b_q << 1;
        end
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

### hdl/packet_insertion_rate_controller.sv
// Top level of the packet insertion rate controller.
//
//  Port group  | Direction | Content
//  s_axis_*    | in        | one event: tuser = req_type, tdata = rate, count, waiting
//  m_axis_*    | out       | one result per event: insert_now, strategy_reset, accel_level
//  cfg_*       | in        | register writes: 0 wait_alert, 1 reset_percent
//
// Packet count events, unknown types and queries with an unknown rate go straight to the
// output step; a rate event restarts on the deviation check or keeps averaging through the
// 64-step serial divide of the deviation sum. A query runs two RATE_WIDTH-step serial
// multiplies, and two more when acceleration needs them. A finished result waits in the
// output register while the next event is accepted; a full output register stalls the state
// machine in its output step. Reset is asynchronous and loads every register's reset value.
module packet_insertion_rate_controller import pirc_pkg::*; #(
  parameter int unsigned RATE_WIDTH  = RateWidthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // bit_rate [31:0], packet_count [47:32], pending_count [63:48]
  input  logic [63:0] s_axis_tdata,
  // req_type [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // insert_now [0], strategy_reset [1], accel_level [9:2], zero [15:10]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned ProdW = COUNT_WIDTH + AccelW + RATE_WIDTH;
  localparam int unsigned ResW  = (ProdW > DivW) ? ProdW : DivW;
  localparam int unsigned BW    = (RATE_WIDTH > SampleW) ? RATE_WIDTH : SampleW;
  localparam int unsigned CmpW  = RATE_WIDTH + PctW + 1;
  localparam int unsigned AvgW  = DivW + 2;
  localparam int unsigned McW   = COUNT_WIDTH + AccelW;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DEV, S_CMP, S_DIVGO, S_DIV,
    S_MUL1, S_MUL2, S_SCALE, S_MUL3, S_MUL4, S_OUT
  } state_e;

  state_e state_q;

  logic [WaitW-1:0] wait_alert_q;
  logic [PctW-1:0]  reset_pct_q;

  logic [SampleW-1:0]    samples_q [2];
  logic [RATE_WIDTH-1:0] first_q   [2];
  logic signed [DiffW-1:0] diff_q  [2];
  logic [RATE_WIDTH-1:0] avg_q     [2];

  logic [COUNT_WIDTH-1:0] main_tot_q, sub_tot_q, main_mark_q, sub_mark_q;
  logic [AccelW-1:0]      factor_q;
  logic [WaitW-1:0]       peak_q;

  logic [2:0]            type_q;
  logic                  sel_q;
  logic [RATE_WIDTH-1:0] rate_q;
  logic [CountInW-1:0]   count_q;
  logic [WaitW-1:0]      wait_q;
  logic [CmpW-1:0]       lhs_q, rhs_q;
  logic [ResW-1:0]       prod_q;
  logic                  ins_q, rst_q;

  logic              out_valid_q, out_ins_q, out_rst_q;
  logic [AccelW-1:0] out_level_q;
  logic              out_load;

  unit_req_t         unit_req;
  logic [DivW-1:0]   unit_a;
  logic [BW-1:0]     unit_b;
  logic              unit_done;
  logic [ResW-1:0]   unit_res;

  // Combinational helpers.
  logic                  sel_now;
  logic [RATE_WIDTH-1:0] dev;
  logic signed [RATE_WIDTH:0] rdiff;
  logic signed [DiffW:0] dsum;
  logic signed [DiffW-1:0] dnew;
  logic [DiffW-1:0]      dmag;
  logic signed [DivW:0]  qs;
  logic signed [AvgW-1:0] avg_sum;
  logic [COUNT_WIDTH:0]  tot_sum;
  logic [COUNT_WIDTH-1:0] dm, ds;
  logic                  avgs_known;

  assign sel_now    = (type_q == REQ_SUB_RATE);
  assign avgs_known = (avg_q[0] != '0) && (avg_q[1] != '0);
  assign dev        = (rate_q >= avg_q[sel_q]) ? rate_q - avg_q[sel_q] : avg_q[sel_q] - rate_q;
  assign rdiff      = $signed({1'b0, rate_q}) - $signed({1'b0, first_q[sel_q]});
  assign dsum       = $signed({diff_q[sel_q][DiffW-1], diff_q[sel_q]}) + (DiffW+1)'(rdiff);
  assign dmag       = diff_q[sel_q][DiffW-1] ? DiffW'(-diff_q[sel_q]) : DiffW'(diff_q[sel_q]);
  assign qs         = diff_q[sel_q][DiffW-1] ? -$signed({1'b0, unit_res[DivW-1:0]})
                                             : $signed({1'b0, unit_res[DivW-1:0]});
  assign avg_sum    = $signed({{(AvgW-RATE_WIDTH){1'b0}}, first_q[sel_q]})
                    + $signed({qs[DivW], qs});
  assign tot_sum    = {1'b0, (type_q == REQ_MAIN_PKTS) ? main_tot_q : sub_tot_q}
                    + (COUNT_WIDTH+1)'(count_q);
  assign dm         = (main_tot_q >= main_mark_q) ? main_tot_q - main_mark_q : '0;
  assign ds         = (sub_tot_q >= sub_mark_q) ? sub_tot_q - sub_mark_q : '0;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    if (dsum[DiffW] != dsum[DiffW-1]) begin
      dnew = dsum[DiffW] ? {1'b1, {(DiffW-1){1'b0}}} : {1'b0, {(DiffW-1){1'b1}}};
    end else begin
      dnew = dsum[DiffW-1:0];
    end
  end

  always_comb begin
    unit_req.start = 1'b0;
    unit_req.op    = OP_MUL;
    unit_a         = '0;
    unit_b         = '0;
    case (state_q)
      S_EXEC: begin
        if (type_q == REQ_QUERY && avgs_known) begin
          unit_req.start = 1'b1;
          unit_a = DivW'(main_tot_q);
          unit_b = BW'(avg_q[1]);
        end
      end
      S_DIVGO: begin
        unit_req.start = 1'b1;
        unit_req.op    = OP_DIV;
        unit_a = dmag;
        unit_b = BW'(samples_q[sel_q]);
      end
      S_MUL1: begin
        unit_req.start = unit_done;
        unit_a = DivW'(sub_tot_q);
        unit_b = BW'(avg_q[0]);
      end
      S_SCALE: begin
        unit_req.start = 1'b1;
        unit_a = DivW'(McW'(dm) * McW'(factor_q));
        unit_b = BW'(avg_q[1]);
      end
      S_MUL3: begin
        unit_req.start = unit_done;
        unit_a = DivW'(ds);
        unit_b = BW'(avg_q[0]);
      end
      default: begin
        unit_req.start = 1'b0;
      end
    endcase
  end

  pirc_seq_unit #(
    .RATE_WIDTH (RATE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (unit_req),
    .a_i   (unit_a),
    .b_i   (unit_b),
    .done_o(unit_done),
    .res_o (unit_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wait_alert_q <= WAIT_ALERT_RST;
      reset_pct_q  <= RESET_PCT_RST;
      for (int i = 0; i < 2; i++) begin
        samples_q[i] <= '0;
        first_q[i]   <= '0;
        diff_q[i]    <= '0;
        avg_q[i]     <= '0;
      end
      main_tot_q  <= '0;
      sub_tot_q   <= '0;
      main_mark_q <= '0;
      sub_mark_q  <= '0;
      factor_q    <= AccelW'(1);
      peak_q      <= '0;
      type_q      <= REQ_MAIN_RATE;
      sel_q       <= 1'b0;
      rate_q      <= '0;
      count_q     <= '0;
      wait_q      <= '0;
      lhs_q       <= '0;
      rhs_q       <= '0;
      prod_q      <= '0;
      ins_q       <= 1'b0;
      rst_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_ins_q   <= 1'b0;
      out_rst_q   <= 1'b0;
      out_level_q <= AccelW'(1);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WAIT_ALERT: wait_alert_q <= cfg_data_i;
          CFG_RESET_PCT:  reset_pct_q  <= cfg_data_i[PctW-1:0];
          default:        wait_alert_q <= wait_alert_q;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            type_q  <= s_axis_tuser;
            rate_q  <= RATE_WIDTH'(s_axis_tdata[BitRateW-1:0]);
            count_q <= s_axis_tdata[47:32];
            wait_q  <= s_axis_tdata[63:48];
            ins_q   <= 1'b0;
            rst_q   <= 1'b0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          sel_q <= sel_now;
          case (type_q)
            REQ_MAIN_RATE, REQ_SUB_RATE: begin
              if (rate_q == '0 || samples_q[sel_now] == '0 || avg_q[sel_now] == '0) begin
                // Zero rate forgets the stream; a first value restarts from it.
                samples_q[sel_now] <= (rate_q == '0) ? '0 : SampleW'(1);
                first_q[sel_now]   <= rate_q;
                diff_q[sel_now]    <= '0;
                avg_q[sel_now]     <= rate_q;
                main_tot_q  <= '0;
                sub_tot_q   <= '0;
                main_mark_q <= '0;
                sub_mark_q  <= '0;
                factor_q    <= AccelW'(1);
                peak_q      <= '0;
                rst_q       <= 1'b1;
                state_q     <= S_OUT;
              end else begin
                state_q <= S_DEV;
              end
            end
            REQ_MAIN_PKTS: begin
              main_tot_q <= tot_sum[COUNT_WIDTH] ? '1 : tot_sum[COUNT_WIDTH-1:0];
              state_q    <= S_OUT;
            end
            REQ_SUB_PKTS: begin
              sub_tot_q <= tot_sum[COUNT_WIDTH] ? '1 : tot_sum[COUNT_WIDTH-1:0];
              state_q   <= S_OUT;
            end
            REQ_QUERY: begin
              if (!avgs_known) begin
                ins_q   <= 1'b1;
                state_q <= S_OUT;
              end else begin
                state_q <= S_MUL1;
              end
            end
            default: begin
              state_q <= S_OUT;
            end
          endcase
        end
        S_DEV: begin
          // floor(dev * 100 / avg) > pct is the same as dev * 100 >= (pct + 1) * avg.
          lhs_q   <= CmpW'(dev) * CmpW'(PERCENT_SCALE);
          rhs_q   <= CmpW'({1'b0, reset_pct_q} + 11'd1) * CmpW'(avg_q[sel_q]);
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (lhs_q >= rhs_q) begin
            samples_q[sel_q] <= SampleW'(1);
            first_q[sel_q]   <= rate_q;
            diff_q[sel_q]    <= '0;
            avg_q[sel_q]     <= rate_q;
            main_tot_q  <= '0;
            sub_tot_q   <= '0;
            main_mark_q <= '0;
            sub_mark_q  <= '0;
            factor_q    <= AccelW'(1);
            peak_q      <= '0;
            rst_q       <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            if (samples_q[sel_q] != '1) begin
              samples_q[sel_q] <= samples_q[sel_q] + SampleW'(1);
            end
            diff_q[sel_q] <= dnew;
            state_q       <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (unit_done) begin
            if (avg_sum > $signed(AvgW'(0))) begin
              if (avg_sum[AvgW-2:RATE_WIDTH] != '0) begin
                avg_q[sel_q] <= '1;
              end else begin
                avg_q[sel_q] <= avg_sum[RATE_WIDTH-1:0];
              end
            end
            state_q <= S_OUT;
          end
        end
        S_MUL1: begin
          if (unit_done) begin
            prod_q  <= unit_res;
            state_q <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (unit_done) begin
            if (prod_q >= unit_res) begin
              ins_q   <= 1'b1;
              state_q <= S_OUT;
            end else if (wait_alert_q == '0 || wait_q < wait_alert_q) begin
              if (factor_q > AccelW'(1)) begin
                factor_q <= AccelW'(1);
                peak_q   <= '0;
              end
              state_q <= S_OUT;
            end else begin
              if (factor_q == AccelW'(1) || wait_q > peak_q) begin
                if (factor_q != '1) begin
                  factor_q <= factor_q + AccelW'(1);
                end
                main_mark_q <= main_tot_q;
                sub_mark_q  <= sub_tot_q;
                peak_q      <= wait_q;
              end
              state_q <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          state_q <= S_MUL3;
        end
        S_MUL3: begin
          if (unit_done) begin
            prod_q  <= unit_res;
            state_q <= S_MUL4;
          end
        end
        S_MUL4: begin
          if (unit_done) begin
            ins_q   <= (prod_q >= unit_res);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_ins_q   <= ins_q;
            out_rst_q   <= rst_q;
            out_level_q <= factor_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_level_q, out_rst_q, out_ins_q};

endmodule
